// ===== rtl/mi3_pkg.sv =====
// shared constants, index tables and types for the 3x3 matrix inverse pipeline
package mi3_pkg;

   // default field widths
   localparam int IN_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 32;

   // matrix size
   localparam int N_ELEM = 9;
   localparam int N_ROW  = 3;

   // cofactor k (adjugate order) = e[a]*e[b] - e[c]*e[d], elements in row order
   localparam int MINOR_IDX [N_ELEM][4] = '{
      '{4, 8, 7, 5},
      '{7, 2, 1, 8},
      '{1, 5, 4, 2},
      '{6, 5, 3, 8},
      '{0, 8, 6, 2},
      '{3, 2, 0, 5},
      '{3, 7, 6, 4},
      '{6, 1, 0, 7},
      '{0, 4, 3, 1}
   };

   // adjugate entries of the first column, paired with the first row for the determinant
   localparam int DET_COL [N_ROW] = '{0, 3, 6};

   // per-lane status carried along the divider
   typedef struct packed {
      logic neg;
      logic ovf;
   } lane_flag_type;

endpackage

// ===== rtl/matrix3x3_inverse.sv =====
// top level of the pipelined 3x3 matrix inverse (adjugate over determinant)
//
//  channel | ports      | payload
//  --------+------------+--------------------------------------------------
//  request | req_t*     | tdata: m11..m33, IN_WIDTH each, Q4.12 signed
//  result  | rsp_t*     | tdata: q11..q33, OUT_WIDTH each, Q16.16; tuser: singular
//
//  one request per cycle while no result is stalled; four adjugate and
//  determinant stages, one divider setup stage, OUT_WIDTH restoring steps
//  (one quotient bit each) and the output register
//  reset clears only the valid bits of every stage
//  a stalled result freezes all stages together; req_tready follows it
module matrix3x3_inverse #(
   parameter int IN_WIDTH  = mi3_pkg::IN_WIDTH_DEF,
   parameter int OUT_WIDTH = mi3_pkg::OUT_WIDTH_DEF,
   localparam int REQ_W = ((mi3_pkg::N_ELEM * IN_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((mi3_pkg::N_ELEM * OUT_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // m11 m12 m13 m21 m22 m23 m31 m32 m33, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // q11 q12 q13 q21 q22 q23 q31 q32 q33, zero pad
   output logic             rsp_tuser   // singular
);

   localparam int MW = 2 * IN_WIDTH + 1;
   localparam int DW = 3 * IN_WIDTH + 3;

   logic                       en;
   logic signed [IN_WIDTH-1:0] elem [mi3_pkg::N_ELEM];
   logic                       adj_valid;
   logic signed [MW-1:0]       adj [mi3_pkg::N_ELEM];
   logic signed [DW-1:0]       det;
   logic                       div_valid;
   logic [OUT_WIDTH-1:0]       quo [mi3_pkg::N_ELEM];
   mi3_pkg::lane_flag_type     flag [mi3_pkg::N_ELEM];
   logic                       div_sing;
   logic [OUT_WIDTH-1:0]       q [mi3_pkg::N_ELEM];

   // whole pipeline advances unless a finished result is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // request unpacking
   always_comb begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         elem[k] = req_tdata[k*IN_WIDTH +: IN_WIDTH];
      end
   end

   mi3_adj #(.IN_WIDTH(IN_WIDTH)) u_adj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .elem_i    (elem),
      .out_valid (adj_valid),
      .adj_o     (adj),
      .det_o     (det)
   );

   mi3_div #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (adj_valid),
      .adj_i     (adj),
      .det_i     (det),
      .out_valid (div_valid),
      .quo_o     (quo),
      .flag_o    (flag),
      .sing_o    (div_sing)
   );

   mi3_sat #(.OUT_WIDTH(OUT_WIDTH)) u_sat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .quo_i     (quo),
      .flag_i    (flag),
      .sing_i    (div_sing),
      .out_valid (rsp_tvalid),
      .q_o       (q),
      .sing_o    (rsp_tuser)
   );

   // result packing
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         rsp_tdata[k*OUT_WIDTH +: OUT_WIDTH] = q[k];
      end
   end

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // singular results carry all-zero elements
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("singular result with nonzero elements");

   // an empty output stage never blocks requests
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

endmodule

// ===== rtl/mi3_adj.sv =====
// adjugate and determinant stages: products, minors, row products, determinant sum
module mi3_adj #(
   parameter int IN_WIDTH = mi3_pkg::IN_WIDTH_DEF,
   localparam int MW = 2 * IN_WIDTH + 1,
   localparam int DW = 3 * IN_WIDTH + 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [IN_WIDTH-1:0] elem_i [mi3_pkg::N_ELEM],
   output logic                       out_valid,
   output logic signed [MW-1:0]       adj_o [mi3_pkg::N_ELEM],
   output logic signed [DW-1:0]       det_o
);

   localparam int PW = 2 * IN_WIDTH;
   localparam int RW = IN_WIDTH + MW;

   logic signed [PW-1:0]       pa_in  [mi3_pkg::N_ELEM];
   logic signed [PW-1:0]       pb_in  [mi3_pkg::N_ELEM];
   logic signed [PW-1:0]       pa_ff  [mi3_pkg::N_ELEM];
   logic signed [PW-1:0]       pb_ff  [mi3_pkg::N_ELEM];
   logic signed [IN_WIDTH-1:0] row1_ff [mi3_pkg::N_ROW];
   logic signed [IN_WIDTH-1:0] row2_ff [mi3_pkg::N_ROW];
   logic signed [MW-1:0]       adj_in  [mi3_pkg::N_ELEM];
   logic signed [MW-1:0]       adj2_ff [mi3_pkg::N_ELEM];
   logic signed [MW-1:0]       adj3_ff [mi3_pkg::N_ELEM];
   logic signed [MW-1:0]       adj4_ff [mi3_pkg::N_ELEM];
   logic signed [RW-1:0]       dp_in  [mi3_pkg::N_ROW];
   logic signed [RW-1:0]       dp_ff  [mi3_pkg::N_ROW];
   logic signed [DW-1:0]       det_in;
   logic signed [DW-1:0]       det_ff;
   logic [3:0]                 val_ff;

   // minor products
   always_comb begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         pa_in[k] = elem_i[mi3_pkg::MINOR_IDX[k][0]] * elem_i[mi3_pkg::MINOR_IDX[k][1]];
         pb_in[k] = elem_i[mi3_pkg::MINOR_IDX[k][2]] * elem_i[mi3_pkg::MINOR_IDX[k][3]];
      end
   end

   // cofactor differences
   always_comb begin
      for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
         adj_in[k] = MW'(pa_ff[k]) - MW'(pb_ff[k]);
      end
   end

   // first row times first adjugate column
   always_comb begin
      for (int j = 0; j < mi3_pkg::N_ROW; j++) begin
         dp_in[j] = row2_ff[j] * adj2_ff[mi3_pkg::DET_COL[j]];
      end
   end

   // determinant sum
   assign det_in = DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < mi3_pkg::N_ELEM; k++) begin
            pa_ff[k]   <= pa_in[k];
            pb_ff[k]   <= pb_in[k];
            adj2_ff[k] <= adj_in[k];
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
         end
         for (int j = 0; j < mi3_pkg::N_ROW; j++) begin
            row1_ff[j] <= elem_i[j];
            row2_ff[j] <= row1_ff[j];
            dp_ff[j]   <= dp_in[j];
         end
         det_ff <= det_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[2:0], in_valid};
      end
   end

   assign out_valid = val_ff[3];
   assign adj_o     = adj4_ff;
   assign det_o     = det_ff;

endmodule

// ===== rtl/mi3_div.sv =====
// scaled division of nine cofactors by the determinant, one quotient bit per restoring stage
module mi3_div #(
   parameter int IN_WIDTH  = mi3_pkg::IN_WIDTH_DEF,
   parameter int OUT_WIDTH = mi3_pkg::OUT_WIDTH_DEF,
   localparam int MW = 2 * IN_WIDTH + 1,
   localparam int DW = 3 * IN_WIDTH + 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [MW-1:0]        adj_i [mi3_pkg::N_ELEM],
   input  logic signed [DW-1:0]        det_i,
   output logic                        out_valid,
   output logic [OUT_WIDTH-1:0]        quo_o [mi3_pkg::N_ELEM],
   output mi3_pkg::lane_flag_type      flag_o [mi3_pkg::N_ELEM],
   output logic                        sing_o
);

   localparam int SH  = (IN_WIDTH - 4) + OUT_WIDTH / 2 + 1;
   localparam int NW0 = (MW + SH) > DW ? (MW + SH) : DW;
   localparam int NW  = NW0 + 1;
   localparam int CW  = (NW > DW + 1 + OUT_WIDTH ? NW : DW + 1 + OUT_WIDTH) + 1;
   localparam int NS  = OUT_WIDTH + 1;

   logic [DW-1:0]          det_mag;
   logic [MW-1:0]          cof_mag [mi3_pkg::N_ELEM];
   logic [CW-1:0]          num     [mi3_pkg::N_ELEM];

   logic [CW-1:0]          rem_in  [NS][mi3_pkg::N_ELEM];
   logic [CW-1:0]          rem_ff  [NS][mi3_pkg::N_ELEM];
   logic [OUT_WIDTH-1:0]   quo_in  [NS][mi3_pkg::N_ELEM];
   logic [OUT_WIDTH-1:0]   quo_ff  [NS][mi3_pkg::N_ELEM];
   mi3_pkg::lane_flag_type flag_in [NS][mi3_pkg::N_ELEM];
   mi3_pkg::lane_flag_type flag_ff [NS][mi3_pkg::N_ELEM];
   logic [CW-1:0]          den_in  [NS];
   logic [CW-1:0]          den_ff  [NS];
   logic [NS-1:0]          sing_in;
   logic [NS-1:0]          sing_ff;
   logic [NS-1:0]          val_ff;
   logic [CW-1:0]          trial;

   // setup and restoring steps, bit OUT_WIDTH-s in stage s
   always_comb begin
      // setup: magnitudes, rounding numerator, overflow of the top quotient bits
      det_mag   = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
      den_in[0] = CW'({det_mag, 1'b0});
      sing_in[0] = (det_i == '0);
      for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
         cof_mag[l] = adj_i[l][MW-1] ? MW'(-adj_i[l]) : MW'(adj_i[l]);
         num[l]     = (CW'(cof_mag[l]) << SH) + CW'(det_mag);
         rem_in[0][l] = num[l];
         quo_in[0][l] = '0;
         flag_in[0][l].neg = adj_i[l][MW-1] ^ det_i[DW-1];
         flag_in[0][l].ovf = (num[l] >= (den_in[0] << OUT_WIDTH));
      end
      // restoring steps
      trial = '0;
      for (int s = 1; s < NS; s++) begin
         den_in[s]  = den_ff[s-1];
         sing_in[s] = sing_ff[s-1];
         for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
            trial        = den_ff[s-1] << (OUT_WIDTH - s);
            flag_in[s][l] = flag_ff[s-1][l];
            quo_in[s][l]  = quo_ff[s-1][l];
            if (rem_ff[s-1][l] >= trial) begin
               rem_in[s][l] = rem_ff[s-1][l] - trial;
               quo_in[s][l][OUT_WIDTH-s] = 1'b1;
            end else begin
               rem_in[s][l] = rem_ff[s-1][l];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            den_ff[s]  <= den_in[s];
            sing_ff[s] <= sing_in[s];
            for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
               rem_ff[s][l]  <= rem_in[s][l];
               quo_ff[s][l]  <= quo_in[s][l];
               flag_ff[s][l] <= flag_in[s][l];
            end
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[NS-2:0], in_valid};
      end
   end

   assign out_valid = val_ff[NS-1];
   assign quo_o     = quo_ff[NS-1];
   assign flag_o    = flag_ff[NS-1];
   assign sing_o    = sing_ff[NS-1];

endmodule

// ===== rtl/mi3_sat.sv =====
// saturation, sign and singular masking into the output register
module mi3_sat #(
   parameter int OUT_WIDTH = mi3_pkg::OUT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [OUT_WIDTH-1:0]   quo_i [mi3_pkg::N_ELEM],
   input  mi3_pkg::lane_flag_type flag_i [mi3_pkg::N_ELEM],
   input  logic                   sing_i,
   output logic                   out_valid,
   output logic [OUT_WIDTH-1:0]   q_o [mi3_pkg::N_ELEM],
   output logic                   sing_o
);

   logic [OUT_WIDTH-1:0] lim [mi3_pkg::N_ELEM];
   logic [OUT_WIDTH-1:0] mag [mi3_pkg::N_ELEM];
   logic [OUT_WIDTH-1:0] q_in [mi3_pkg::N_ELEM];
   logic [OUT_WIDTH-1:0] q_ff [mi3_pkg::N_ELEM];
   logic                 sing_ff;
   logic                 val_ff;

   // clamp magnitude to the signed range, then apply the sign
   always_comb begin
      for (int l = 0; l < mi3_pkg::N_ELEM; l++) begin
         lim[l] = {1'b0, {(OUT_WIDTH-1){1'b1}}} + OUT_WIDTH'(flag_i[l].neg);
         mag[l] = (flag_i[l].ovf || quo_i[l] > lim[l]) ? lim[l] : quo_i[l];
         if (sing_i) begin
            q_in[l] = '0;
         end else if (flag_i[l].neg) begin
            q_in[l] = -mag[l];
         end else begin
            q_in[l] = mag[l];
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         sing_ff <= sing_i;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
      end else if (en) begin
         val_ff <= in_valid;
      end
   end

   assign out_valid = val_ff;
   assign q_o       = q_ff;
   assign sing_o    = sing_ff;

endmodule

// ===== tb/matrix3x3_inverse_tb.sv =====
// testbench for the 3x3 matrix inverse: queued request driver, result monitor, exact predictor
`timescale 1ns / 100ps

module matrix3x3_inverse_tb;

   localparam int IW = mi3_pkg::IN_WIDTH_DEF;
   localparam int OW = mi3_pkg::OUT_WIDTH_DEF;
   localparam int NE = mi3_pkg::N_ELEM;
   localparam int REQ_W = ((NE * IW + 7) / 8) * 8;
   localparam int RSP_W = ((NE * OW + 7) / 8) * 8;
   localparam int FRAC_SHIFT = (IW - 4) + OW / 2;
   localparam int LATENCY = OW + 6;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [NE-1:0][OW-1:0] q;
      logic                  singular;
   } inverse_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // m11 m12 m13 m21 m22 m23 m31 m32 m33, zero pad
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;       // q11 .. q33, zero pad
   logic             rsp_tuser;       // singular

   logic [REQ_W-1:0] pending_matrices [$];
   inverse_type      expected_inverses [$];
   int               n_errors = 0;
   int               n_results = 0;
   int               n_singular = 0;
   int               idle_cycles = 0;
   int               req_gap = 0;
   int               rsp_gap = 0;
   bit               stim_done = 1'b0;

   matrix3x3_inverse i_dut (.*);

   always #5 clock = ~clock;

   // gap length: mostly short, sometimes long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // exact adjugate over determinant, rounded half away from zero, saturated
   function automatic inverse_type invert_matrix(logic [REQ_W-1:0] packed_m);
      logic signed [63:0]  e [NE];
      logic signed [127:0] adj [NE];
      logic signed [127:0] det;
      logic [127:0]        mag_c, mag_d, num, quo, lim;
      logic                neg;
      inverse_type         r;
      for (int i = 0; i < NE; i++)
         e[i] = 64'(signed'(packed_m[i*IW +: IW]));
      for (int k = 0; k < NE; k++)
         adj[k] = 128'(e[mi3_pkg::MINOR_IDX[k][0]] * e[mi3_pkg::MINOR_IDX[k][1]])
                - 128'(e[mi3_pkg::MINOR_IDX[k][2]] * e[mi3_pkg::MINOR_IDX[k][3]]);
      det = 128'(e[0]) * adj[0] + 128'(e[1]) * adj[3] + 128'(e[2]) * adj[6];
      r.singular = (det == 0);
      for (int k = 0; k < NE; k++) begin
         r.q[k] = '0;
         if (!r.singular) begin
            mag_c = adj[k][127] ? -adj[k] : adj[k];
            mag_d = det[127] ? -det : det;
            neg = adj[k][127] ^ det[127];
            num = ((mag_c << FRAC_SHIFT) << 1) + mag_d;
            quo = num / (mag_d << 1);
            lim = (128'(1) << (OW - 1)) - 1 + 128'(neg);
            if (quo > lim) quo = lim;
            r.q[k] = neg ? OW'(-quo) : OW'(quo);
         end
      end
      return r;
   endfunction

   function automatic logic [REQ_W-1:0] random_matrix(int mode);
      logic [REQ_W-1:0] m;
      int sel;
      m = '0;
      for (int i = 0; i < NE; i++) begin
         case (mode)
            0: m[i*IW +: IW] = IW'($urandom);
            1: m[i*IW +: IW] = IW'($urandom_range(0, 8191) - 4096);
            default: begin
               sel = $urandom_range(0, 4);
               m[i*IW +: IW] = (sel == 0) ? 16'h8000 : (sel == 1) ? 16'h7fff :
                               (sel == 2) ? 16'h0000 : IW'($urandom_range(0, 3) - 1);
            end
         endcase
      end
      // sometimes make a row copy of another so the matrix is singular
      if ($urandom_range(0, 9) == 0) m[3*IW +: 3*IW] = m[0 +: 3*IW];
      return m;
   endfunction

   function automatic logic [REQ_W-1:0] diag_matrix(logic [IW-1:0] a, logic [IW-1:0] b,
                                                    logic [IW-1:0] c);
      logic [REQ_W-1:0] m;
      m = '0;
      m[0 +: IW] = a;
      m[4*IW +: IW] = b;
      m[8*IW +: IW] = c;
      return m;
   endfunction

   // stimulus
   initial begin
      logic [REQ_W-1:0] m;
      pending_matrices.push_back(diag_matrix(16'h1000, 16'h1000, 16'h1000));
      pending_matrices.push_back(diag_matrix(16'h0001, 16'h0001, 16'h0001));
      pending_matrices.push_back(diag_matrix(16'h8000, 16'h8000, 16'h8000));
      pending_matrices.push_back(diag_matrix(16'h7fff, 16'h7fff, 16'h7fff));
      pending_matrices.push_back(diag_matrix(16'hffff, 16'h0001, 16'h2000));
      pending_matrices.push_back(diag_matrix(16'h0003, 16'hfffd, 16'h0007));
      pending_matrices.push_back('0);
      m = '0;
      for (int i = 0; i < NE; i++) m[i*IW +: IW] = 16'h7fff;
      pending_matrices.push_back(m);
      for (int i = 0; i < NE; i++) m[i*IW +: IW] = 16'h8000;
      pending_matrices.push_back(m);
      for (int i = 0; i < NE; i++) m[i*IW +: IW] = (i % 2) ? 16'h8000 : 16'h7fff;
      pending_matrices.push_back(m);
      for (int i = 0; i < NE; i++) m[i*IW +: IW] = (i % 4 == 0) ? 16'h8000 : 16'h0000;
      m[1*IW +: IW] = 16'h7fff;
      pending_matrices.push_back(m);
      for (int i = 0; i < NE; i++) m[i*IW +: IW] = IW'(i + 1);
      pending_matrices.push_back(m);
      m[8*IW +: IW] = 16'h000a;
      pending_matrices.push_back(m);
      for (int i = 0; i < 1300; i++)
         pending_matrices.push_back(random_matrix($urandom_range(0, 2)));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_inverses.push_back(invert_matrix(req_tdata));
            void'(pending_matrices.pop_front());
            req_gap = pick_gap();
         end
         if (req_tvalid && !req_tready) begin
            // hold the request
         end else if (req_gap > 0 || pending_matrices.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_tvalid <= 1'b0;
            if (pending_matrices.size() == 0) stim_done = 1'b1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_matrices[0];
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      inverse_type exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_inverses.size() == 0) begin
               $error("result with no request waiting");
               n_errors++;
            end else begin
               exp_r = expected_inverses.pop_front();
               if (exp_r.singular) n_singular++;
               for (int k = 0; k < NE; k++)
                  if (rsp_tdata[k*OW +: OW] !== exp_r.q[k]) begin
                     $error("q%0d%0d: expected %h, got %h", k / 3 + 1, k % 3 + 1,
                            exp_r.q[k], rsp_tdata[k*OW +: OW]);
                     n_errors++;
                  end
               if (rsp_tuser !== exp_r.singular) begin
                  $error("singular: expected %b, got %b", exp_r.singular, rsp_tuser);
                  n_errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", idle_cycles);
            $display("matrix3x3_inverse: mismatch");
            $finish;
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done && expected_inverses.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("checked %0d inverses, %0d of them singular, with random stalls on both sides",
               n_results, n_singular);
      if (n_errors == 0 && expected_inverses.size() == 0) begin
         $display("matrix3x3_inverse: match");
      end else begin
         $display("matrix3x3_inverse: mismatch");
      end
      $finish;
   end

endmodule
